// ===== rtl/oapdp_pkg.sv =====
// ----------------------------------------------------------------------------
// Optimal accuracy profile DP package
// Score and posterior types, row buffer entry layout, saturating score
// arithmetic and configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package oapdp_pkg;

   localparam int SCORE_W   = 32;
   localparam int POST_W    = 16;
   localparam int CFG_W     = 11;
   localparam int CSR_IDX_W = 1;

   typedef logic signed [SCORE_W-1:0] score_type;
   typedef logic [POST_W-1:0]         post_type;
   typedef logic [CFG_W-1:0]          cfg_data_type;
   typedef logic [CSR_IDX_W-1:0]      csr_index_type;

   localparam score_type NEG_INF   = score_type'(32'h8000_0000);
   localparam score_type POS_MAX   = score_type'(32'h7fff_ffff);
   localparam score_type SCORE_ZERO = score_type'(32'h0000_0000);

   localparam csr_index_type CSR_MODEL_LENGTH = 1'b0;
   localparam csr_index_type CSR_LOCAL_MODE   = 1'b1;

   // One row buffer entry: the match, insert and delete scores of one node.
   typedef struct packed {
      score_type match_score;
      score_type insert_score;
      score_type delete_score;
   } row_entry_type;

   localparam int ENTRY_W = $bits(row_entry_type);

   localparam row_entry_type ENTRY_NEG_INF = '{NEG_INF, NEG_INF, NEG_INF};

   // Cell held in the compute stage, in the cycle after its transaction.
   typedef struct packed {
      logic          valid;
      logic          last_node;
      logic          final_row;
      logic          fwd_hit;
      row_entry_type fwd_entry;
      post_type      post_match;
      post_type      post_insert;
      post_type      post_ntail;
      post_type      post_jloop;
      post_type      post_ctail;
   } cell_item_type;

   // Row buffer write request from the compute stage.
   typedef struct packed {
      logic          en;
      row_entry_type data;
   } row_write_type;

   function automatic score_type score_max(score_type a, score_type b);
      return (a > b) ? a : b;
   endfunction

   // Minus infinity absorbs the addend; the posterior is never negative, so
   // only positive overflow needs saturation.
   function automatic score_type score_add(score_type a, post_type p);
      logic signed [SCORE_W:0] sum;
      sum = {a[SCORE_W-1], a} + $signed({1'b0, {(SCORE_W-POST_W){1'b0}}, p});
      if (a == NEG_INF) begin
         return NEG_INF;
      end else if (sum[SCORE_W] != sum[SCORE_W-1]) begin
         return POS_MAX;
      end else begin
         return score_type'(sum[SCORE_W-1:0]);
      end
   endfunction

endpackage

`default_nettype wire

// ===== rtl/oapdp_req_if.sv =====
// ----------------------------------------------------------------------------
// Optimal accuracy profile DP cell channel
// Valid/ready channel carrying one DP cell's posteriors.
// ----------------------------------------------------------------------------
`default_nettype none

interface oapdp_req_if;
   import oapdp_pkg::*;

   logic     valid;
   logic     ready;
   post_type post_match;
   post_type post_insert;
   post_type post_ntail;
   post_type post_jloop;
   post_type post_ctail;
   logic     final_row;

   modport source (
      output valid, post_match, post_insert, post_ntail, post_jloop, post_ctail,
             final_row,
      input  ready
   );

   modport sink (
      input  valid, post_match, post_insert, post_ntail, post_jloop, post_ctail,
             final_row,
      output ready
   );
endinterface

`default_nettype wire

// ===== rtl/oapdp_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Optimal accuracy profile DP result channel
// Valid/ready channel carrying the accuracy score of one sequence.
// ----------------------------------------------------------------------------
`default_nettype none

interface oapdp_rsp_if;
   import oapdp_pkg::*;

   logic      valid;
   logic      ready;
   score_type accuracy_score;

   modport source (
      output valid, accuracy_score,
      input  ready
   );

   modport sink (
      input  valid, accuracy_score,
      output ready
   );
endinterface

`default_nettype wire

// ===== rtl/oapdp_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port; read data is registered, and a read of
// the address being written returns the old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module oapdp_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 1025
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

`default_nettype wire

// ===== rtl/oapdp_cell.sv =====
// ----------------------------------------------------------------------------
// Optimal accuracy profile DP cell stage
// Computes one cell from the previous row's entry and the running scores,
// produces the row buffer write-back and, at the end of the final row, the
// accuracy score.
// ----------------------------------------------------------------------------
`default_nettype none

module oapdp_cell #(
   parameter int NODE_W = 11
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     local_mode,
   input  wire oapdp_pkg::cell_item_type item,
   input  wire logic [NODE_W-1:0]        node,
   input  wire oapdp_pkg::row_entry_type rd_entry,
   output oapdp_pkg::row_write_type      wr,
   output logic                          result_valid,
   output oapdp_pkg::score_type          result_score
);
   import oapdp_pkg::*;

   row_entry_type     diag_ff,   diag_in;
   score_type         left_m_ff, left_m_in;
   score_type         left_d_ff, left_d_in;
   score_type         end_ff,    end_in;
   score_type         ntail_ff,  ntail_in;
   score_type         jloop_ff,  jloop_in;
   score_type         ctail_ff,  ctail_in;
   score_type         begin_ff,  begin_in;
   // Entries 1..fill_ff were written since the last clear; others read as
   // minus infinity.
   logic [NODE_W-1:0] fill_ff,   fill_in;

   row_entry_type     old_entry;
   score_type         match_new;
   score_type         delete_new;
   score_type         insert_new;
   score_type         end_last;
   score_type         jloop_new;
   score_type         ctail_new;
   score_type         ntail_new;
   logic [NODE_W-1:0] fill_max;

   always_comb begin
      if (node > fill_ff) begin
         old_entry = ENTRY_NEG_INF;
      end else if (item.fwd_hit) begin
         old_entry = item.fwd_entry;
      end else begin
         old_entry = rd_entry;
      end

      match_new = score_add(score_max(score_max(diag_ff.match_score, diag_ff.insert_score),
                                      score_max(diag_ff.delete_score, begin_ff)),
                            item.post_match);
      delete_new = score_max(left_m_ff, left_d_ff);
      insert_new = score_add(score_max(old_entry.match_score, old_entry.insert_score),
                             item.post_insert);
      end_last  = score_max(end_ff, score_max(match_new, delete_new));
      jloop_new = score_max(score_add(jloop_ff, item.post_jloop), end_last);
      ctail_new = score_max(score_add(ctail_ff, item.post_ctail), end_last);
      ntail_new = score_add(ntail_ff, item.post_ntail);
      fill_max  = (node > fill_ff) ? node : fill_ff;

      diag_in   = diag_ff;
      left_m_in = left_m_ff;
      left_d_in = left_d_ff;
      end_in    = end_ff;
      ntail_in  = ntail_ff;
      jloop_in  = jloop_ff;
      ctail_in  = ctail_ff;
      begin_in  = begin_ff;
      fill_in   = fill_ff;

      wr.en                = item.valid;
      wr.data.match_score  = match_new;
      wr.data.insert_score = item.last_node ? NEG_INF : insert_new;
      wr.data.delete_score = delete_new;

      result_valid = item.valid && item.last_node && item.final_row;
      result_score = ctail_new;

      if (item.valid) begin
         if (!item.last_node) begin
            end_in    = score_max(end_ff, local_mode ? match_new : SCORE_ZERO);
            diag_in   = old_entry;
            left_m_in = match_new;
            left_d_in = delete_new;
            fill_in   = fill_max;
         end else begin
            diag_in   = ENTRY_NEG_INF;
            left_m_in = NEG_INF;
            left_d_in = NEG_INF;
            end_in    = NEG_INF;
            if (item.final_row) begin
               // Sequence done: the whole DP returns to its reset state.
               ntail_in = SCORE_ZERO;
               jloop_in = NEG_INF;
               ctail_in = NEG_INF;
               begin_in = SCORE_ZERO;
               fill_in  = '0;
            end else begin
               ntail_in = ntail_new;
               jloop_in = jloop_new;
               ctail_in = ctail_new;
               begin_in = score_max(ntail_new, jloop_new);
               fill_in  = fill_max;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         diag_ff   <= ENTRY_NEG_INF;
         left_m_ff <= NEG_INF;
         left_d_ff <= NEG_INF;
         end_ff    <= NEG_INF;
         ntail_ff  <= SCORE_ZERO;
         jloop_ff  <= NEG_INF;
         ctail_ff  <= NEG_INF;
         begin_ff  <= SCORE_ZERO;
         fill_ff   <= '0;
      end else begin
         diag_ff   <= diag_in;
         left_m_ff <= left_m_in;
         left_d_ff <= left_d_in;
         end_ff    <= end_in;
         ntail_ff  <= ntail_in;
         jloop_ff  <= jloop_in;
         ctail_ff  <= ctail_in;
         begin_ff  <= begin_in;
         fill_ff   <= fill_in;
      end
   end
endmodule

`default_nettype wire

// ===== rtl/oapdp_rsp_buf.sv =====
// ----------------------------------------------------------------------------
// Optimal accuracy profile DP result buffer
// Two-entry queue between the compute stage and the result channel, with a
// room flag for the cell channel.
// ----------------------------------------------------------------------------
`default_nettype none

module oapdp_rsp_buf (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire oapdp_pkg::score_type push_score,
   output logic                      room,
   oapdp_rsp_if.source               rsp
);
   import oapdp_pkg::*;

   logic [1:0] count_ff, count_in;
   score_type  head_ff,  head_in;
   score_type  tail_ff,  tail_in;
   logic       pop;

   assign pop = rsp.valid && rsp.ready;

   always_comb begin
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
      head_in  = head_ff;
      tail_in  = tail_ff;
      unique case (count_ff)
         2'd0: begin
            if (push) head_in = push_score;
         end
         2'd1: begin
            if (push && pop) head_in = push_score;
            else if (push)   tail_in = push_score;
         end
         default: begin
            if (pop) begin
               head_in = tail_ff;
               if (push) tail_in = push_score;
            end
         end
      endcase
      // A transaction taken now can push in the next cycle.
      room = (count_in <= 2'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   assign rsp.valid          = (count_ff != 2'd0);
   assign rsp.accuracy_score = head_ff;
endmodule

`default_nettype wire

// ===== rtl/optimal_accuracy_profile_dp_top.sv =====
// ----------------------------------------------------------------------------
// Optimal accuracy profile DP
// Max-sum optimal accuracy DP over profile HMM posteriors, one cell per
// transaction, row buffers in a single RAM.
// ----------------------------------------------------------------------------
//  channel   direction  payload                                  transaction
//  req_ch    in         five Q0.16 posteriors, final_row         one DP cell
//  rsp_ch    out        accuracy_score, Q16.16                   one sequence
//  csr_*     in         model_length, local_mode                 register write
//
// One cell is taken per cycle while the result queue has room. The node
// counter and row RAM read address are set at the transaction; the cell is
// computed and written back in the next cycle, and its result is registered
// in the result queue before it is offered. Back-to-back reads of the entry
// still being written are forwarded. Reset needs no clearing pass: a fill
// count marks unwritten RAM entries. The cell channel stalls only when the
// two-entry result queue could overflow.
`default_nettype none

module optimal_accuracy_profile_dp_top #(
   parameter int MAX_NODES = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_wr_en,
   input  wire oapdp_pkg::csr_index_type csr_index,
   input  wire oapdp_pkg::cfg_data_type  csr_wdata,
   oapdp_req_if.sink                     req_ch,
   oapdp_rsp_if.source                   rsp_ch
);
   import oapdp_pkg::*;

   localparam int DEPTH  = MAX_NODES + 1;
   localparam int NODE_W = $clog2(DEPTH);
   localparam int LEN_W  = (NODE_W > CFG_W) ? NODE_W : CFG_W;

   cfg_data_type      model_length_ff, model_length_in;
   logic              local_mode_ff,   local_mode_in;
   logic [NODE_W-1:0] node_ff,         node_in;
   logic [NODE_W-1:0] s1_node_ff;
   cell_item_type     s1_item_ff,      s1_item_in;

   logic [LEN_W-1:0]  len_ext;
   logic [LEN_W-1:0]  len_eff;
   logic              last_node;
   logic              accept;
   logic              room;
   row_entry_type     rd_entry;
   logic [ENTRY_W-1:0] rd_bits;
   row_write_type     wr;
   logic              result_valid;
   score_type         result_score;

   assign accept       = req_ch.valid && room;
   assign req_ch.ready = room;

   always_comb begin
      model_length_in = model_length_ff;
      local_mode_in   = local_mode_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MODEL_LENGTH: model_length_in = csr_wdata;
            CSR_LOCAL_MODE:   local_mode_in   = csr_wdata[0];
         endcase
      end
   end

   always_comb begin
      len_ext = LEN_W'(model_length_ff);
      if (len_ext == '0) begin
         len_eff = LEN_W'(1);
      end else if (len_ext > LEN_W'(MAX_NODES)) begin
         len_eff = LEN_W'(MAX_NODES);
      end else begin
         len_eff = len_ext;
      end
      // A node count that reaches or passes the length closes the row.
      last_node = (LEN_W'(node_ff) >= len_eff);

      node_in = node_ff;
      if (accept) begin
         node_in = last_node ? NODE_W'(1) : node_ff + NODE_W'(1);
      end

      s1_item_in.valid       = accept;
      s1_item_in.last_node   = last_node;
      s1_item_in.final_row   = req_ch.final_row;
      s1_item_in.fwd_hit     = wr.en && (s1_node_ff == node_ff);
      s1_item_in.fwd_entry   = wr.data;
      s1_item_in.post_match  = req_ch.post_match;
      s1_item_in.post_insert = req_ch.post_insert;
      s1_item_in.post_ntail  = req_ch.post_ntail;
      s1_item_in.post_jloop  = req_ch.post_jloop;
      s1_item_in.post_ctail  = req_ch.post_ctail;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         model_length_ff  <= CFG_W'(1);
         local_mode_ff    <= 1'b1;
         node_ff          <= NODE_W'(1);
         s1_item_ff.valid <= 1'b0;
      end else begin
         model_length_ff  <= model_length_in;
         local_mode_ff    <= local_mode_in;
         node_ff          <= node_in;
         s1_item_ff.valid <= s1_item_in.valid;
      end
      s1_item_ff.last_node   <= s1_item_in.last_node;
      s1_item_ff.final_row   <= s1_item_in.final_row;
      s1_item_ff.fwd_hit     <= s1_item_in.fwd_hit;
      s1_item_ff.fwd_entry   <= s1_item_in.fwd_entry;
      s1_item_ff.post_match  <= s1_item_in.post_match;
      s1_item_ff.post_insert <= s1_item_in.post_insert;
      s1_item_ff.post_ntail  <= s1_item_in.post_ntail;
      s1_item_ff.post_jloop  <= s1_item_in.post_jloop;
      s1_item_ff.post_ctail  <= s1_item_in.post_ctail;
      s1_node_ff             <= node_ff;
   end

   oapdp_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (wr.en),
      .wr_addr (s1_node_ff),
      .wr_data (wr.data),
      .rd_addr (node_ff),
      .rd_data (rd_bits)
   );

   assign rd_entry = row_entry_type'(rd_bits);

   oapdp_cell #(
      .NODE_W (NODE_W)
   ) u_cell (
      .clock        (clock),
      .reset        (reset),
      .local_mode   (local_mode_ff),
      .item         (s1_item_ff),
      .node         (s1_node_ff),
      .rd_entry     (rd_entry),
      .wr           (wr),
      .result_valid (result_valid),
      .result_score (result_score)
   );

   oapdp_rsp_buf u_rsp_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (result_valid),
      .push_score (result_score),
      .room       (room),
      .rsp        (rsp_ch)
   );
endmodule

`default_nettype wire

// ===== rtl/oapdp_checker.sv =====
// ----------------------------------------------------------------------------
// Optimal accuracy profile DP port checker
// Concurrent checks on the top level's channels, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module oapdp_checker (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_ready,
   input wire logic                 req_final_row,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire oapdp_pkg::score_type rsp_score
);
   // A stalled result stays offered.
   a_rsp_hold_valid : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_hold_score : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_score))
      else $error("result score changed while stalled");

   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered right after reset");

   // With the queue empty, a result follows its final-row transaction through
   // the compute stage and the result queue register.
   a_rsp_cause : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_final_row, 2))
      else $error("result without a final-row transaction");
endmodule

bind optimal_accuracy_profile_dp_top oapdp_checker u_oapdp_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .req_final_row (req_ch.final_row),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_score     (rsp_ch.accuracy_score)
);

`default_nettype wire
